// File: rtl/integer_matrix_multiply_core_macros.svh
// assertion macros for the integer matrix multiply core
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define IMM_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("imm check failed");
`define IMM_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("imm check failed");
`endif

// File: rtl/imm_pkg.sv
// shared types and constants for the integer matrix multiply core
package imm_pkg;
   localparam int DATA_W = 32;
   localparam logic [1:0] EW_8 = 2'd0;
   localparam logic [1:0] EW_16 = 2'd1;
   localparam logic [1:0] EW_32 = 2'd2;
   localparam logic [1:0] REG_A_ROWS = 2'd0;
   localparam logic [1:0] REG_INNER = 2'd1;
   localparam logic [1:0] REG_B_COLS = 2'd2;
   localparam logic [1:0] REG_EW = 2'd3;
   typedef struct packed {
      logic shift_a;
      logic shift_b;
   } cell_ctl_type;
endpackage

// File: rtl/imm_cell.sv
// one chain cell: holds an a and a b word, hands both to its neighbour, multiplies them
module imm_cell (
   input  logic                       clock,
   input  imm_pkg::cell_ctl_type      ctl,
   input  logic [imm_pkg::DATA_W-1:0] a_in,
   input  logic [imm_pkg::DATA_W-1:0] b_in,
   output logic [imm_pkg::DATA_W-1:0] a_out,
   output logic [imm_pkg::DATA_W-1:0] b_out,
   output logic [imm_pkg::DATA_W-1:0] prod_out
);
   logic [imm_pkg::DATA_W-1:0] a_ff, b_ff, prod_ff;
   always_ff @(posedge clock) begin
      if (ctl.shift_a) a_ff <= a_in;
      if (ctl.shift_b) b_ff <= b_in;
      prod_ff <= a_ff * b_ff;
   end
   assign a_out = a_ff;
   assign b_out = b_ff;
   assign prod_out = prod_ff;
endmodule

// File: rtl/integer_matrix_multiply_core.sv
// top level of the integer matrix multiply core
// A (a_rows x inner_dim) and then B (inner_dim x b_cols) arrive as words, each row-major,
// one word per cycle while no register is being written, and are kept in two memories.
// After the last B word the input stalls while C = A*B leaves in row-major order with
// rsp_tlast on the final entry; each entry wraps to the element width and is zero-extended.
// Dimensions of 0 count as 1, larger than MAX_DIM as MAX_DIM, and width code 3 means 32
// bits. For each C row the row of A is shifted into a chain of MAX_DIM cells; for each
// entry the B column is shifted in, the cells multiply, one accumulator adds the cell
// products and the entry is held until taken. The chain is filled by a single memory read
// a cycle and the sum adds one cell product a cycle. A register write abandons a partial
// load and must not come while a product is in flight.
module integer_matrix_multiply_core #(
   parameter int MAX_DIM = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // element_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // product_value
   output logic        rsp_tlast,   // last_element
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW = $clog2(DEPTH);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int KW = $clog2(MAX_DIM);
   localparam int CW = AW + 1;
   localparam logic [DW-1:0] D_ONE = DW'(1);
   localparam logic [CW-1:0] C_ONE = CW'(1);
   localparam logic [2:0] S_LOAD = 3'd0, S_AROW = 3'd1, S_BCOL = 3'd2, S_MUL = 3'd3,
                          S_SUM = 3'd4, S_OUT = 3'd5;

   logic [3:0] rows_ff, inner_ff, cols_ff;
   logic [1:0] ew_ff;
   logic [2:0] st_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] r_ff, c_ff, k_ff, sent_ff, sk_ff;
   logic [DW-1:0] rows_e, inner_e, cols_e;
   logic [CW-1:0] a_tot, b_tot, bidx;
   logic [AW-1:0] a_addr, b_addr;
   logic [imm_pkg::DATA_W-1:0] a_mem [DEPTH];
   logic [imm_pkg::DATA_W-1:0] b_mem [DEPTH];
   logic [imm_pkg::DATA_W-1:0] a_rd_ff, b_rd_ff;
   logic sha_ff, shb_ff;
   logic [imm_pkg::DATA_W-1:0] acc_ff, acc_sum;
   logic [31:0] out_ff, mask;
   logic outv_ff, last_ff;
   logic acc_hs, in_b, b_done;
   logic rsp_wait;
   logic [32:0] rsp_word;
   imm_pkg::cell_ctl_type ctl;
   logic [imm_pkg::DATA_W-1:0] ach [MAX_DIM+1];
   logic [imm_pkg::DATA_W-1:0] bch [MAX_DIM+1];
   logic [imm_pkg::DATA_W-1:0] prods [MAX_DIM];

   function automatic logic [DW-1:0] eff(input logic [3:0] v);
      if (v == 4'd0) return DW'(1);
      if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
      return DW'(v);
   endfunction
   assign rows_e = eff(rows_ff);
   assign inner_e = eff(inner_ff);
   assign cols_e = eff(cols_ff);
   assign a_tot = CW'(rows_e) * CW'(inner_e);
   assign b_tot = CW'(inner_e) * CW'(cols_e);

   assign req_tready = (st_ff == S_LOAD) && !csr_we;
   assign acc_hs = req_tvalid && req_tready;
   assign in_b = cnt_ff >= a_tot;
   assign bidx = cnt_ff - a_tot;
   assign b_done = in_b && (bidx + C_ONE == b_tot);

   // address generation for compute reads
   assign a_addr = AW'(r_ff) * AW'(inner_e) + AW'(k_ff);
   assign b_addr = AW'(k_ff) * AW'(cols_e) + AW'(c_ff);

   always_ff @(posedge clock) begin
      if (acc_hs && !in_b) a_mem[cnt_ff[AW-1:0]] <= req_tdata;
      if (acc_hs && in_b) b_mem[bidx[AW-1:0]] <= req_tdata;
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
   end

   // cell chain
   assign ctl.shift_a = sha_ff;
   assign ctl.shift_b = shb_ff;
   assign ach[0] = a_rd_ff;
   assign bch[0] = b_rd_ff;
   genvar g;
   generate
      for (g = 0; g < MAX_DIM; g++) begin : g_cell
         imm_cell u_cell (.clock(clock), .ctl(ctl), .a_in(ach[g]), .b_in(bch[g]),
            .a_out(ach[g+1]), .b_out(bch[g+1]), .prod_out(prods[g]));
      end
   endgenerate

   assign acc_sum = acc_ff + prods[sk_ff[KW-1:0]];

   always_comb begin
      case (ew_ff)
         imm_pkg::EW_8:  mask = 32'h0000_00ff;
         imm_pkg::EW_16: mask = 32'h0000_ffff;
         default:        mask = 32'hffff_ffff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 4'd8; inner_ff <= 4'd8; cols_ff <= 4'd8; ew_ff <= imm_pkg::EW_32;
         st_ff <= S_LOAD; cnt_ff <= '0; r_ff <= '0; c_ff <= '0; k_ff <= '0;
         sent_ff <= '0; sk_ff <= '0; sha_ff <= 1'b0; shb_ff <= 1'b0; acc_ff <= '0;
         out_ff <= '0; outv_ff <= 1'b0; last_ff <= 1'b0;
      end else begin
         sha_ff <= 1'b0;
         shb_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               imm_pkg::REG_A_ROWS: rows_ff <= csr_wdata;
               imm_pkg::REG_INNER:  inner_ff <= csr_wdata;
               imm_pkg::REG_B_COLS: cols_ff <= csr_wdata;
               imm_pkg::REG_EW:     ew_ff <= csr_wdata[1:0];
               default: ;
            endcase
            cnt_ff <= '0;
         end
         case (st_ff)
            S_LOAD: begin
               if (acc_hs) begin
                  if (b_done) begin
                     cnt_ff <= '0; st_ff <= S_AROW; r_ff <= '0; c_ff <= '0;
                     k_ff <= inner_e - D_ONE; sent_ff <= '0;
                  end else cnt_ff <= cnt_ff + C_ONE;
               end
            end
            S_AROW: begin
               // last index read first so that word k settles in cell k
               if (sent_ff == inner_e) begin
                  st_ff <= S_BCOL; sent_ff <= '0; k_ff <= inner_e - D_ONE;
               end else begin
                  sha_ff <= 1'b1; sent_ff <= sent_ff + D_ONE; k_ff <= k_ff - D_ONE;
               end
            end
            S_BCOL: begin
               if (sent_ff == inner_e) begin
                  st_ff <= S_MUL; sent_ff <= '0;
               end else begin
                  shb_ff <= 1'b1; sent_ff <= sent_ff + D_ONE; k_ff <= k_ff - D_ONE;
               end
            end
            S_MUL: begin
               acc_ff <= '0; sk_ff <= '0; st_ff <= S_SUM;
            end
            S_SUM: begin
               // one cell product added per cycle
               if (sk_ff + D_ONE == inner_e) begin
                  out_ff <= acc_sum & mask; outv_ff <= 1'b1;
                  last_ff <= (r_ff + D_ONE == rows_e) && (c_ff + D_ONE == cols_e);
                  st_ff <= S_OUT;
               end else begin
                  acc_ff <= acc_sum;
                  sk_ff <= sk_ff + D_ONE;
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  outv_ff <= 1'b0; sent_ff <= '0; k_ff <= inner_e - D_ONE;
                  if (last_ff) st_ff <= S_LOAD;
                  else if (c_ff + D_ONE == cols_e) begin
                     c_ff <= '0; r_ff <= r_ff + D_ONE; st_ff <= S_AROW;
                  end else begin
                     c_ff <= c_ff + D_ONE; st_ff <= S_BCOL;
                  end
               end
            end
            default: st_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = outv_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tlast = last_ff;

   assign rsp_wait = rsp_tvalid && !rsp_tready;
   assign rsp_word = {rsp_tlast, rsp_tdata};

`include "integer_matrix_multiply_core_macros.svh"
   `IMM_ASSERT_IMPL(a_no_accept_busy, clock, reset, st_ff != S_LOAD, !req_tready)
   `IMM_ASSERT_NEXT(a_out_holds, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_word))
   `IMM_ASSERT_IMPL(a_valid_in_out, clock, reset, rsp_tvalid, st_ff == S_OUT)
endmodule
